[rtl/smt_pkg.sv]
// Shared types, codes and sizes of the sorted multiset table.
`default_nettype none
package smt_pkg;

  // Field widths of the request and result channels.
  localparam int unsigned DataW     = 32;
  localparam int unsigned FuncW     = 2;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned CountW    = 7;
  localparam int unsigned InTdataW  = 32;
  localparam int unsigned InTuserW  = 2;
  localparam int unsigned OutFieldW = StatusW + 1 + CountW + 1 + 2 * DataW;
  localparam int unsigned OutTdataW = ((OutFieldW + 7) / 8) * 8;

  // Default number of entries held by the table.
  localparam int unsigned DefCapacity = 64;

  // Operation codes; the unused code behaves as a search.
  localparam logic [FuncW-1:0] FuncInsert = 2'd0;
  localparam logic [FuncW-1:0] FuncDelete = 2'd1;
  localparam logic [FuncW-1:0] FuncSearch = 2'd2;

  // Result status codes.
  localparam logic [StatusW-1:0] StatusDone     = 2'd0;
  localparam logic [StatusW-1:0] StatusNotFound = 2'd1;
  localparam logic [StatusW-1:0] StatusFull     = 2'd2;

  // What one cell shows its neighbours.
  typedef struct packed {
    logic                    occ;
    logic                    lt;
    logic signed [DataW-1:0] entry;
  } link_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic signed [DataW-1:0] value;
  } cmd_t;

endpackage
`default_nettype wire

[rtl/smt_cell.sv]
// One slot of the sorted row: holds an entry and shifts with its neighbours.
`default_nettype none
module smt_cell (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  smt_pkg::cmd_t   cmd_i,
  input  smt_pkg::link_t  prev_i,
  input  smt_pkg::link_t  next_i,
  output smt_pkg::link_t  link_o,
  output logic            hit_o,
  output logic            last_o
);

  logic                            occ_q, occ_d;
  logic signed [smt_pkg::DataW-1:0] entry_q, entry_d;
  logic                            lt;

  // The entry sorts strictly below the requested value.
  assign lt = occ_q && (entry_q < cmd_i.value);

  // This slot is the lower bound and holds an equal value.
  assign hit_o  = occ_q && prev_i.lt && !lt && (entry_q == cmd_i.value);
  assign last_o = occ_q && !next_i.occ;

  assign link_o.occ   = occ_q;
  assign link_o.lt    = lt;
  assign link_o.entry = entry_q;

  // Slots at or above the lower bound move up on insert and down on delete.
  always_comb begin
    occ_d   = occ_q;
    entry_d = entry_q;
    if (cmd_i.ins) begin
      occ_d = prev_i.occ;
      if (!lt) begin
        entry_d = prev_i.lt ? cmd_i.value : prev_i.entry;
      end
    end else if (cmd_i.del) begin
      occ_d = next_i.occ;
      if (!lt) begin
        entry_d = next_i.entry;
      end
    end
  end

  // Occupancy is control state; the entry itself needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
`default_nettype wire

[rtl/sorted_multiset_table.sv]
// The result of an accepted request is registered and offered the cycle after.
// Throughput: one request per cycle while results are taken; every cell of the
// row compares with the request value in parallel and the row shifts in that cycle.
// A new request is taken while the previous result is being taken.
// Reset: asynchronous, active low; empties the table and drops any pending result.
`default_nettype none
module sorted_multiset_table #(
  parameter int unsigned CAPACITY = smt_pkg::DefCapacity
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // value[31:0]
  input  wire  [smt_pkg::InTdataW-1:0]      s_axis_tdata,
  // func[1:0]
  input  wire  [smt_pkg::InTuserW-1:0]      s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // status[1:0], found[2], count[9:3], empty_res[10], smallest[42:11],
  // largest[74:43], zero padding above
  output logic [smt_pkg::OutTdataW-1:0]     m_axis_tdata
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  smt_pkg::link_t                  links [CAPACITY];
  smt_pkg::link_t                  prevs [CAPACITY];
  smt_pkg::link_t                  nexts [CAPACITY];
  logic [CAPACITY-1:0]             hits;
  logic [CAPACITY-1:0]             lasts;
  smt_pkg::cmd_t                   cmd;

  logic                            accept;
  logic [smt_pkg::FuncW-1:0]       func;
  logic                            present;
  logic                            full;
  logic [CntW-1:0]                 count_q, count_d;
  logic                            out_valid_q;
  logic [smt_pkg::StatusW-1:0]     status_q, status_d;
  logic                            found_q;
  logic [CntW+smt_pkg::CountW-1:0] count_ext;
  logic signed [smt_pkg::DataW-1:0] smallest;
  logic signed [smt_pkg::DataW-1:0] largest;

  // A request is taken whenever the result slot is free or being emptied.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign func          = s_axis_tuser[smt_pkg::FuncW-1:0];

  assign present = |hits;
  assign full    = links[CAPACITY-1].occ;

  assign cmd.value = $signed(s_axis_tdata[smt_pkg::DataW-1:0]);
  assign cmd.ins   = accept && (func == smt_pkg::FuncInsert) && !full;
  assign cmd.del   = accept && (func == smt_pkg::FuncDelete) && present;

  // Neighbour wiring; the row ends act as an always-lower head and an empty tail.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == 0) begin
        prevs[i] = '{occ: 1'b1, lt: 1'b1, entry: '0};
      end else begin
        prevs[i] = links[i-1];
      end
      if (i == CAPACITY - 1) begin
        nexts[i] = '{occ: 1'b0, lt: 1'b0, entry: '0};
      end else begin
        nexts[i] = links[i+1];
      end
    end
  end

  // The row of cells.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    smt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .prev_i (prevs[g]),
      .next_i (nexts[g]),
      .link_o (links[g]),
      .hit_o  (hits[g]),
      .last_o (lasts[g])
    );
  end

  // Status of the request and the new count.
  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + 1'b1;
    end else if (cmd.del) begin
      count_d = count_q - 1'b1;
    end
    unique case (func)
      smt_pkg::FuncInsert: status_d = full ? smt_pkg::StatusFull : smt_pkg::StatusDone;
      default:             status_d = present ? smt_pkg::StatusDone
                                              : smt_pkg::StatusNotFound;
    endcase
  end

  // Result register and the stored count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      found_q  <= present;
    end
  end

  // Head and tail of the row; the state holds still while a result waits.
  always_comb begin
    smallest = links[0].occ ? links[0].entry : '0;
    largest  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      largest = largest | (lasts[i] ? links[i].entry : '0);
    end
  end

  assign count_ext     = {{smt_pkg::CountW{1'b0}}, count_q};
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(smt_pkg::OutTdataW - smt_pkg::OutFieldW){1'b0}},
                          largest, smallest, !links[0].occ,
                          count_ext[smt_pkg::CountW-1:0], found_q, status_q};

endmodule
`default_nettype wire

[rtl/smt_checker.sv]
// Port-level checks of the sorted multiset table, bound to its top level.
`default_nettype none
module smt_checker (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           m_axis_tvalid,
  input wire                           m_axis_tready,
  input wire [smt_pkg::OutTdataW-1:0]  m_axis_tdata
);

  logic [1:0]        status;
  logic              found;
  logic [6:0]        count;
  logic              empty;
  logic signed [31:0] smallest;
  logic signed [31:0] largest;

  assign status   = m_axis_tdata[1:0];
  assign found    = m_axis_tdata[2];
  assign count    = m_axis_tdata[9:3];
  assign empty    = m_axis_tdata[10];
  assign smallest = m_axis_tdata[42:11];
  assign largest  = m_axis_tdata[74:43];

  // A stalled result stays on offer.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // An empty table reports zero for both ends and a zero count.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && empty |-> (smallest == 0) && (largest == 0) && (count == 0))
    else $error("empty table shows stored values");

  // The head of the row never sorts above its tail.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !empty |-> smallest <= largest)
    else $error("smallest exceeds largest");

  // A miss never claims the value was present.
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == smt_pkg::StatusNotFound) |-> !found)
    else $error("not-found result with found set");

  // A full table cannot be empty.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == smt_pkg::StatusFull) |-> !empty)
    else $error("full status on an empty table");

endmodule

bind sorted_multiset_table smt_checker u_smt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

[sim/tb_top.sv]
// Self-checking bench for the sorted multiset table: queue-fed driver, checking monitor.
`default_nettype none
module tb_top;

  localparam int unsigned TableDepth    = smt_pkg::DefCapacity;
  localparam int          ClkPeriod     = 12;
  localparam int          WatchdogLimit = 4000;
  localparam int          PhaseItems    = 100;
  // The spare operation code, which the table treats as a search.
  localparam logic [smt_pkg::FuncW-1:0] FuncSpare = 2'd3;

  typedef struct {
    logic [smt_pkg::FuncW-1:0]        func;
    logic signed [smt_pkg::DataW-1:0] value;
  } table_req_t;

  typedef struct {
    logic [smt_pkg::StatusW-1:0]      status;
    logic                             found;
    logic [smt_pkg::CountW-1:0]       count;
    logic                             empty;
    logic signed [smt_pkg::DataW-1:0] smallest;
    logic signed [smt_pkg::DataW-1:0] largest;
  } table_res_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [smt_pkg::InTdataW-1:0]  s_axis_tdata;   // value[31:0]
  logic [smt_pkg::InTuserW-1:0]  s_axis_tuser;   // func[1:0]
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  // status, found, count, empty_res, smallest, largest
  logic [smt_pkg::OutTdataW-1:0] m_axis_tdata;

  sorted_multiset_table #(
    .CAPACITY (TableDepth)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Requests waiting to be driven, and results the table still owes.
  table_req_t pending_requests[$];
  table_res_t owed_results[$];

  // Shadow copy of the sorted store.
  logic signed [smt_pkg::DataW-1:0] shadow_vals[TableDepth];
  int unsigned                      shadow_fill;

  // Generation-side view of what is stored, in no particular order.
  logic signed [smt_pkg::DataW-1:0] gen_pool[$];

  int  send_idle_pct;
  int  recv_stall_pct;
  int  error_count;
  int  requests_taken;
  int  results_checked;
  int  full_drops;
  int  misses;
  int  stall_cycles;
  logic req_taken;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Predict one request against the shadow store and update it.
  function automatic table_res_t predict_table_op(input table_req_t req);
    table_res_t  res;
    int unsigned pos;
    int unsigned j;
    logic        present;
    pos = 0;
    while (pos < shadow_fill && shadow_vals[pos] < req.value) pos++;
    present = (pos < shadow_fill) && (shadow_vals[pos] == req.value);
    res.found = present;
    if (req.func == smt_pkg::FuncInsert) begin
      if (shadow_fill >= TableDepth) begin
        res.status = smt_pkg::StatusFull;
      end else begin
        for (j = shadow_fill; j > pos; j--) shadow_vals[j] = shadow_vals[j-1];
        shadow_vals[pos] = req.value;
        shadow_fill++;
        res.status = smt_pkg::StatusDone;
      end
    end else if (req.func == smt_pkg::FuncDelete) begin
      if (present) begin
        for (j = pos; j + 1 < shadow_fill; j++) shadow_vals[j] = shadow_vals[j+1];
        shadow_fill--;
        res.status = smt_pkg::StatusDone;
      end else begin
        res.status = smt_pkg::StatusNotFound;
      end
    end else begin
      // Search and the spare code leave the store alone.
      res.status = present ? smt_pkg::StatusDone : smt_pkg::StatusNotFound;
    end
    res.count = shadow_fill[smt_pkg::CountW-1:0];
    res.empty = (shadow_fill == 0);
    res.smallest = (shadow_fill == 0) ? '0 : shadow_vals[0];
    res.largest  = (shadow_fill == 0) ? '0 : shadow_vals[shadow_fill-1];
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  // Driver: new request or hold the current one at the falling edge.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || req_taken) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_requests[0].value;
          s_axis_tuser  <= pending_requests[0].func;
          void'(pending_requests.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: check results, predict accepted requests, watch for hangs.
  always @(posedge clk_i) begin
    table_res_t got;
    table_res_t want;
    table_req_t req;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status   = m_axis_tdata[1:0];
        got.found    = m_axis_tdata[2];
        got.count    = m_axis_tdata[9:3];
        got.empty    = m_axis_tdata[10];
        got.smallest = m_axis_tdata[42:11];
        got.largest  = m_axis_tdata[74:43];
        results_checked++;
        if (owed_results.size() == 0) begin
          report_mismatch("result arrived with none outstanding");
        end else begin
          want = owed_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
          if (got.found !== want.found)
            report_mismatch($sformatf("found %0d, wanted %0d", got.found, want.found));
          if (got.count !== want.count)
            report_mismatch($sformatf("count %0d, wanted %0d", got.count, want.count));
          if (got.empty !== want.empty)
            report_mismatch($sformatf("empty %0d, wanted %0d", got.empty, want.empty));
          if (got.smallest !== want.smallest)
            report_mismatch($sformatf("smallest %0d, wanted %0d",
                                      got.smallest, want.smallest));
          if (got.largest !== want.largest)
            report_mismatch($sformatf("largest %0d, wanted %0d",
                                      got.largest, want.largest));
          if (m_axis_tdata[smt_pkg::OutTdataW-1:75] !== '0)
            report_mismatch("padding bits not zero");
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req.func  = s_axis_tuser;
        req.value = s_axis_tdata;
        want = predict_table_op(req);
        if (want.status == smt_pkg::StatusFull) full_drops++;
        if (want.status == smt_pkg::StatusNotFound) misses++;
        owed_results.push_back(want);
        requests_taken++;
      end
      req_taken <= s_axis_tvalid && s_axis_tready;
      // Only cycles with work outstanding count towards a hang.
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (s_axis_tvalid || owed_results.size() != 0) begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles + 1 >= WatchdogLimit) begin
          $display("watchdog: no progress for %0d cycles", WatchdogLimit);
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  // Queue a request and keep the generation-side pool in step.
  task automatic queue_request(input logic [smt_pkg::FuncW-1:0] func,
                               input logic signed [smt_pkg::DataW-1:0] v);
    table_req_t req;
    int         i;
    req.func  = func;
    req.value = v;
    pending_requests.push_back(req);
    if (func == smt_pkg::FuncInsert) begin
      if (gen_pool.size() < TableDepth) gen_pool.push_back(v);
    end else if (func == smt_pkg::FuncDelete) begin
      for (i = 0; i < gen_pool.size(); i++) begin
        if (gen_pool[i] == v) begin
          gen_pool.delete(i);
          break;
        end
      end
    end
  endtask

  // Values: often a narrow band to make duplicates, some extremes, the rest anything.
  function automatic logic signed [smt_pkg::DataW-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 40) return $signed($urandom_range(6)) - 3;
    if (r < 45) return 32'sh8000_0000;
    if (r < 50) return 32'sh7fff_ffff;
    return $urandom;
  endfunction

  function automatic logic signed [smt_pkg::DataW-1:0] pick_stored_or_any();
    if (gen_pool.size() != 0 && $urandom_range(99) < 75)
      return gen_pool[$urandom_range(gen_pool.size() - 1)];
    return pick_value();
  endfunction

  task automatic wait_drained();
    while (pending_requests.size() != 0 || s_axis_tvalid || owed_results.size() != 0)
      @(posedge clk_i);
  endtask

  // Random requests: fill runs push the table to full, drain runs empty it again.
  task automatic queue_random_phase(input int items, inout bit filling);
    int r;
    int n;
    for (n = 0; n < items; n++) begin
      r = $urandom_range(99);
      if (gen_pool.size() >= TableDepth && filling && $urandom_range(3) == 0) filling = 0;
      if (gen_pool.size() == 0) filling = 1;
      if (r < 5) begin
        queue_request(FuncSpare, pick_stored_or_any());
      end else if (r < 15) begin
        queue_request(smt_pkg::FuncSearch, pick_stored_or_any());
      end else if (r < (filling ? 85 : 30)) begin
        queue_request(smt_pkg::FuncInsert, pick_value());
      end else begin
        queue_request(smt_pkg::FuncDelete, pick_stored_or_any());
      end
    end
  endtask

  // Stimulus and phase control.
  initial begin
    bit filling;
    int p;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = smt_pkg::FuncSearch;
    m_axis_tready  = 1'b0;
    req_taken      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    requests_taken = 0;
    results_checked = 0;
    full_drops     = 0;
    misses         = 0;
    stall_cycles   = 0;
    shadow_fill    = 0;
    filling        = 1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty store, extremes, duplicates, absent values, the spare code.
    queue_request(smt_pkg::FuncSearch, 32'sd0);
    queue_request(smt_pkg::FuncDelete, 32'sd5);
    queue_request(smt_pkg::FuncInsert, 32'sd0);
    queue_request(smt_pkg::FuncSearch, 32'sd0);
    queue_request(smt_pkg::FuncInsert, 32'sh8000_0000);
    queue_request(smt_pkg::FuncInsert, 32'sh7fff_ffff);
    queue_request(smt_pkg::FuncInsert, -32'sd1);
    queue_request(smt_pkg::FuncInsert, 32'sd1);
    queue_request(smt_pkg::FuncInsert, 32'sd0);
    queue_request(smt_pkg::FuncSearch, 32'sh8000_0000);
    queue_request(smt_pkg::FuncDelete, 32'sd0);
    queue_request(smt_pkg::FuncSearch, 32'sd0);
    queue_request(smt_pkg::FuncDelete, 32'sd0);
    queue_request(smt_pkg::FuncSearch, 32'sd0);
    queue_request(smt_pkg::FuncDelete, 32'sd7);
    queue_request(FuncSpare, 32'sh7fff_ffff);
    queue_request(FuncSpare, 32'sh5555_aaaa);
    queue_request(smt_pkg::FuncDelete, 32'sh7fff_ffff);
    queue_request(smt_pkg::FuncDelete, 32'sh8000_0000);
    queue_request(smt_pkg::FuncDelete, -32'sd1);
    queue_request(smt_pkg::FuncDelete, 32'sd1);
    queue_request(smt_pkg::FuncDelete, 32'sd1);
    queue_request(smt_pkg::FuncSearch, 32'sh7fff_ffff);
    wait_drained();

    // Random phases under changing back-pressure.
    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      queue_random_phase(PhaseItems, filling);
      wait_drained();
    end
    repeat (4) @(posedge clk_i);

    $display("Covered %0d requests and %0d results, with %0d full-table drops and %0d misses.",
             requests_taken, results_checked, full_drops, misses);
    $display("Four back-pressure phases were run; %0d mismatches were found.", error_count);
    if (error_count == 0 && owed_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
